/* hw/rtl/sid_pkg.sv */
// Shared types and constants for the set intersection and difference block.
`default_nettype none
package sid_pkg;
	localparam int ELEM_W        = 31;
	localparam int OP_W          = 2;
	localparam int KIND_W        = 2;
	localparam int MATCH_W       = 6;
	localparam int MATCH_MAX     = 63;
	localparam int CAPACITY_DEF  = 32;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_APPENDED = 2'd0,
		KIND_DROPPED  = 2'd1,
		KIND_CLEARED  = 2'd2,
		KIND_QUERY    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	typedef struct packed {
		kind_t              kind;
		logic [ELEM_W-1:0]  elem;
		logic [MATCH_W-1:0] match;
		logic               diff;
		logic               last;
	} sid_res_t;
endpackage
`default_nettype wire

/* hw/rtl/sid_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module sid_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/sid_ctrl.sv */
// Sequencer: store fill count, entry scan with one comparator, result build.
`default_nettype none
module sid_ctrl #(
	parameter int SET_CAPACITY = sid_pkg::CAPACITY_DEF,
	localparam int ADDR_W = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_ready,
	input  wire logic [sid_pkg::OP_W-1:0]      op,
	input  wire logic [sid_pkg::ELEM_W-1:0]    element_value,
	input  wire logic                          final_item,
	output logic                               ram_we,
	output logic      [ADDR_W-1:0]             ram_waddr,
	output logic      [sid_pkg::ELEM_W-1:0]    ram_wdata,
	output logic                               ram_re,
	output logic      [ADDR_W-1:0]             ram_raddr,
	input  wire logic [sid_pkg::ELEM_W-1:0]    ram_rdata,
	output logic                               res_valid,
	input  wire logic                          res_ready,
	output sid_pkg::sid_res_t                  res
);
	import sid_pkg::*;

	localparam int CNT_W = $clog2(SET_CAPACITY + 1);
	localparam int SAT_W = (CNT_W > MATCH_W) ? CNT_W : MATCH_W;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  lim_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  hits_q;
	logic [ELEM_W-1:0] elem_q;
	logic              last_q;
	kind_t             kind_q;
	logic              cmp_v_s1;
	logic              accept;
	logic              full;
	logic              scan_end;
	logic [SAT_W-1:0]  hits_ext;

	assign accept   = req_valid && (state_q == S_IDLE);
	assign full     = (count_q == CNT_W'(SET_CAPACITY));
	assign scan_end = (idx_q == lim_q - CNT_W'(1));

	// Store write: appends land at the fill count, only while idle
	assign ram_we    = accept && (op_t'(op) == OP_APPEND) && !full;
	assign ram_waddr = count_q[ADDR_W-1:0];
	assign ram_wdata = element_value;

	// Scan read: one entry per cycle, compared in the following cycle
	assign ram_re    = (state_q == S_SCAN);
	assign ram_raddr = idx_q[ADDR_W-1:0];

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake outputs
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					unique case (op_t'(op))
						OP_CLEAR:  state_d = S_FINISH;
						OP_APPEND: state_d = S_FINISH;
						OP_QUERY:  state_d = (count_q == '0) ? S_FINISH : S_SCAN;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_SCAN: begin
				if (scan_end) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Fill count and compare pipeline flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			cmp_v_s1 <= 1'b0;
		end else begin
			cmp_v_s1 <= (state_q == S_SCAN);
			if (accept && (op_t'(op) == OP_CLEAR)) begin
				count_q <= '0;
			end else if (ram_we) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// Latch the transaction, advance the scan index, count hits
	always_ff @(posedge clk) begin
		if (accept) begin
			elem_q <= element_value;
			last_q <= final_item;
			lim_q  <= count_q;
			idx_q  <= '0;
			hits_q <= '0;
			unique case (op_t'(op))
				OP_CLEAR:  kind_q <= KIND_CLEARED;
				OP_APPEND: kind_q <= full ? KIND_DROPPED : KIND_APPENDED;
				default:   kind_q <= KIND_QUERY;
			endcase
		end else begin
			if (state_q == S_SCAN) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (cmp_v_s1 && (ram_rdata == elem_q)) begin
				hits_q <= hits_q + CNT_W'(1);
			end
		end
	end

	// Build the result; non-query results carry zero fields
	assign hits_ext = SAT_W'(hits_q);
	always_comb begin
		res.kind  = kind_q;
		res.elem  = '0;
		res.match = '0;
		res.diff  = 1'b0;
		res.last  = 1'b0;
		if (kind_q == KIND_QUERY) begin
			res.elem  = elem_q;
			res.match = (hits_ext > SAT_W'(MATCH_MAX)) ? MATCH_W'(MATCH_MAX)
				: hits_ext[MATCH_W-1:0];
			res.diff  = (hits_q == '0);
			res.last  = last_q;
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(SET_CAPACITY))
		else $error("fill count beyond capacity");
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (idx_q < lim_q))
		else $error("scan read beyond written entries");
	a_hits_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH) |-> (hits_q <= lim_q))
		else $error("hit count exceeds scanned entries");
	a_drain_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN) |-> cmp_v_s1)
		else $error("last compare missing at drain");
`endif
endmodule
`default_nettype wire

/* hw/rtl/set_intersection_difference.sv */
// Top level: set B store, scan sequencer and result register.
`default_nettype none
// Keeps up to SET_CAPACITY elements of set B in a synchronous RAM and
// answers each clear, append or query with one result. With the output side
// free, a clear, an append and a query of an empty store go from acceptance
// to the finish state, where the result register loads, and then back to
// idle, where the next request is taken. A query of a non-empty store reads
// the stored entries through the single RAM read port, one entry per cycle
// into one comparator, then passes through the drain state to the finish
// state, where its result loads, and returns to idle. Requests are taken
// one at a time; a finished result waits in the output register while the
// next request is accepted. Op code 3 is accepted and produces no result.
// The store needs no clearing after reset: entries beyond the fill count
// are never read.
module set_intersection_difference #(
	parameter int SET_CAPACITY = sid_pkg::CAPACITY_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_ready,
	input  wire logic [sid_pkg::OP_W-1:0]      op,
	input  wire logic [sid_pkg::ELEM_W-1:0]    element_value,
	input  wire logic                          final_item,
	output logic                               rsp_valid,
	input  wire logic                          rsp_ready,
	output logic      [sid_pkg::KIND_W-1:0]    kind,
	output logic      [sid_pkg::ELEM_W-1:0]    element_value_res,
	output logic      [sid_pkg::MATCH_W-1:0]   match_count,
	output logic                               in_difference,
	output logic                               last_of_set
);
	import sid_pkg::*;

	localparam int ADDR_W = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ELEM_W-1:0] ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [ELEM_W-1:0] ram_rdata;
	logic              res_valid;
	logic              res_ready;
	sid_res_t          res;
	sid_res_t          out_q;
	logic              out_valid_q;

	sid_ram #(
		.WIDTH (ELEM_W),
		.DEPTH (SET_CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	sid_ctrl #(
		.SET_CAPACITY (SET_CAPACITY)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.op            (op),
		.element_value (element_value),
		.final_item    (final_item),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.ram_re        (ram_re),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res           (res)
	);

	// Output register: load when empty or being drained
	assign res_ready = !out_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp_valid         = out_valid_q;
	assign kind              = out_q.kind;
	assign element_value_res = out_q.elem;
	assign match_count       = out_q.match;
	assign in_difference     = out_q.diff;
	assign last_of_set       = out_q.last;

`ifndef ASSERT_OFF
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(kind)))
		else $error("pending transaction lost");
	a_query_diff: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (kind == KIND_QUERY)) |->
		(in_difference == (match_count == '0)))
		else $error("difference flag disagrees with match count");
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |-> !req_ready)
		else $error("request taken while result stalled");
`endif
endmodule
`default_nettype wire

/* verif/sid_checker.sv */
// Checker for the set intersection and difference block: predicts and compares every answer.
module sid_checker
	import sid_pkg::*;
#(
	parameter int SET_CAPACITY = CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_ready,
	input  logic [OP_W-1:0]    op,
	input  logic [ELEM_W-1:0]  element_value,
	input  logic               final_item,
	input  logic               rsp_valid,
	input  logic               rsp_ready,
	input  logic [KIND_W-1:0]  kind,
	input  logic [ELEM_W-1:0]  element_value_res,
	input  logic [MATCH_W-1:0] match_count,
	input  logic               in_difference,
	input  logic               last_of_set,
	output int                 fail_count,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Own copy of set B and its fill level
	logic [ELEM_W-1:0] set_b [SET_CAPACITY];
	int                set_b_fill;

	// Answers still owed by the block, oldest first
	sid_res_t          awaited_answers [$];
	int                mismatches;

	// Update the copy of set B and queue the answer one request transaction earns
	task automatic apply_request(input logic [OP_W-1:0] code, input logic [ELEM_W-1:0] value,
			input logic last);
		sid_res_t answer;
		int       hits;
		answer = '0;
		hits   = 0;
		case (code)
			OP_CLEAR: begin
				set_b_fill = 0;
				answer.kind = KIND_CLEARED;
				awaited_answers.push_back(answer);
			end
			OP_APPEND: begin
				if (set_b_fill >= SET_CAPACITY) begin
					answer.kind = KIND_DROPPED;
				end else begin
					set_b[set_b_fill] = value;
					set_b_fill++;
					answer.kind = KIND_APPENDED;
				end
				awaited_answers.push_back(answer);
			end
			OP_QUERY: begin
				for (int i = 0; i < set_b_fill; i++)
					if (set_b[i] == value)
						hits++;
				answer.kind  = KIND_QUERY;
				answer.elem  = value;
				answer.match = (hits > MATCH_MAX) ? MATCH_W'(MATCH_MAX) : MATCH_W'(hits);
				answer.diff  = (hits == 0);
				answer.last  = last;
				awaited_answers.push_back(answer);
			end
			default: begin
				// unused code: nothing stored, nothing answered
			end
		endcase
	endtask

	// Compare one result transaction with the oldest awaited answer
	task automatic check_answer();
		sid_res_t seen;
		sid_res_t wanted;
		seen = {kind, element_value_res, match_count, in_difference, last_of_set};
		if (awaited_answers.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("[%0t] result with nothing awaited: kind=%0d elem=%h match=%0d diff=%b last=%b",
					$realtime, seen.kind, seen.elem, seen.match, seen.diff, seen.last);
		end else begin
			wanted = awaited_answers.pop_front();
			if (seen.kind !== wanted.kind || seen.elem !== wanted.elem
					|| seen.match !== wanted.match || seen.diff !== wanted.diff
					|| seen.last !== wanted.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] mismatch: expected kind=%0d elem=%h match=%0d diff=%b last=%b, got kind=%0d elem=%h match=%0d diff=%b last=%b",
						$realtime, wanted.kind, wanted.elem, wanted.match, wanted.diff,
						wanted.last, seen.kind, seen.elem, seen.match, seen.diff, seen.last);
			end
		end
	endtask

	// Watch both channels; results are checked before the request of the same edge
	always @(posedge clk) begin
		if (!arst_n) begin
			set_b_fill = 0;
		end else begin
			if (rsp_valid && rsp_ready)
				check_answer();
			if (req_valid && req_ready)
				apply_request(op, element_value, final_item);
		end
		fail_count <= mismatches;
		pending    <= awaited_answers.size();
	end

	initial begin
		mismatches = 0;
		set_b_fill = 0;
	end
endmodule

/* verif/testbench.sv */
// Testbench top: clock, reset, request and result traffic, and the verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import sid_pkg::*;

	localparam int             CLK_PERIOD   = 10;
	localparam int             ITEMS        = 500;
	localparam int             HOLD_AFTER   = 150;
	localparam int             HOLD_CYCLES  = 300;
	localparam int             DRAIN_CYCLES = 40;
	localparam int             CYCLE_LIMIT  = 400000;
	localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
	localparam logic [ELEM_W-1:0] ELEM_TOP  = {ELEM_W{1'b1}};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               req_valid;
	logic               req_ready;
	logic [OP_W-1:0]    op;
	logic [ELEM_W-1:0]  element_value;
	logic               final_item;
	logic               rsp_valid;
	logic               rsp_ready;
	logic [KIND_W-1:0]  kind;
	logic [ELEM_W-1:0]  element_value_res;
	logic [MATCH_W-1:0] match_count;
	logic               in_difference;
	logic               last_of_set;
	int                 fail_count;
	int                 pending;

	int                 requests_sent;
	bit                 calm_send;
	int                 results_taken;
	int                 stall_left;
	bit                 hold_done;
	bit                 calm_sink;
	int                 cycles;

	set_intersection_difference #(
		.SET_CAPACITY(CAPACITY_DEF)
	) dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.req_valid        (req_valid),
		.req_ready        (req_ready),
		.op               (op),
		.element_value    (element_value),
		.final_item       (final_item),
		.rsp_valid        (rsp_valid),
		.rsp_ready        (rsp_ready),
		.kind             (kind),
		.element_value_res(element_value_res),
		.match_count      (match_count),
		.in_difference    (in_difference),
		.last_of_set      (last_of_set)
	);

	sid_checker #(
		.SET_CAPACITY(CAPACITY_DEF)
	) answer_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.req_valid        (req_valid),
		.req_ready        (req_ready),
		.op               (op),
		.element_value    (element_value),
		.final_item       (final_item),
		.rsp_valid        (rsp_valid),
		.rsp_ready        (rsp_ready),
		.kind             (kind),
		.element_value_res(element_value_res),
		.match_count      (match_count),
		.in_difference    (in_difference),
		.last_of_set      (last_of_set),
		.fail_count       (fail_count),
		.pending          (pending)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Idle length: mostly none or short, now and then long; none at all in calm stretches
	function automatic int pick_gap(input bit calm);
		int roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Element value biased towards the extremes and a narrow band that repeats
	function automatic logic [ELEM_W-1:0] pick_value();
		int          roll;
		logic [31:0] raw;
		roll = $urandom_range(0, 9);
		raw  = $urandom();
		if (roll == 0)
			return '0;
		if (roll == 1)
			return ELEM_TOP;
		if (roll == 2)
			return ELEM_W'($urandom_range(1, 16));
		return raw[ELEM_W-1:0];
	endfunction

	// Offer one request transaction after a random gap and hold it until taken
	task automatic offer(input logic [OP_W-1:0] code, input logic [ELEM_W-1:0] value,
			input logic last);
		int gap;
		gap = pick_gap(calm_send);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid     <= 1'b1;
		op            <= code;
		element_value <= value;
		final_item    <= last;
		do @(posedge clk); while (!req_ready);
		if (code != OP_UNUSED)
			requests_sent++;
	endtask

	// Stop offering until every awaited answer has come back
	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// One load and query round, usually after a clear, or a burst of noise
	task automatic run_sequence(input bit force_fill);
		logic [ELEM_W-1:0] pool [8];
		logic [ELEM_W-1:0] value;
		int                pool_n;
		int                n_app;
		int                n_q;
		int                roll;
		bit                fill;
		roll      = force_fill ? 99 : $urandom_range(0, 99);
		calm_send = ($urandom_range(0, 3) == 0);
		if (roll < 10) begin
			repeat ($urandom_range(1, 6))
				offer(OP_W'($urandom_range(0, 3)), pick_value(), 1'($urandom_range(0, 1)));
		end else begin
			fill   = (roll >= 80);
			pool_n = force_fill ? 1 : (fill ? $urandom_range(1, 2) : $urandom_range(1, 8));
			for (int i = 0; i < pool_n; i++)
				pool[i] = pick_value();
			// skip the clear now and then so that loads stack up
			if (roll >= 15)
				offer(OP_CLEAR, pick_value(), 1'($urandom_range(0, 1)));
			n_app = fill ? $urandom_range(30, 36) : $urandom_range(0, 12);
			if (force_fill)
				n_app = CAPACITY_DEF + 2;
			repeat (n_app)
				offer(OP_APPEND, pool[$urandom_range(0, pool_n - 1)], 1'($urandom_range(0, 1)));
			n_q = $urandom_range(1, 10);
			for (int q = 0; q < n_q; q++) begin
				value = ($urandom_range(0, 9) < 6) ? pool[$urandom_range(0, pool_n - 1)]
					: pick_value();
				offer(OP_QUERY, value, q == n_q - 1);
			end
		end
	endtask

	// Result side: random stalls, calm stretches and one long hold-off
	initial begin
		rsp_ready     <= 1'b0;
		results_taken = 0;
		stall_left    = 0;
		hold_done     = 1'b0;
		calm_sink     = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready)
				results_taken++;
			if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else if (!hold_done && results_taken >= HOLD_AFTER) begin
				hold_done  = 1'b1;
				stall_left = HOLD_CYCLES - 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
				stall_left = pick_gap(calm_sink);
			end
			if ($urandom_range(0, 199) == 0)
				calm_sink = !calm_sink;
		end
	end

	// Watchdog
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	// Stimulus and verdict
	initial begin
		arst_n        <= 1'b0;
		req_valid     <= 1'b0;
		op            <= OP_CLEAR;
		element_value <= '0;
		final_item    <= 1'b0;
		requests_sent = 0;
		calm_send     = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty store, unused code, extremes, zero element, duplicates
		offer(OP_QUERY, ELEM_W'(5), 1'b0);
		offer(OP_UNUSED, ELEM_TOP, 1'b1);
		offer(OP_CLEAR, '0, 1'b0);
		offer(OP_APPEND, ELEM_TOP, 1'b0);
		offer(OP_APPEND, '0, 1'b1);
		offer(OP_APPEND, ELEM_TOP, 1'b0);
		offer(OP_APPEND, ELEM_W'(1), 1'b0);
		offer(OP_QUERY, ELEM_TOP, 1'b0);
		offer(OP_QUERY, '0, 1'b0);
		offer(OP_QUERY, ELEM_W'(1), 1'b1);
		offer(OP_QUERY, ELEM_W'(2), 1'b0);
		offer(OP_QUERY, ELEM_W'('h5555_5555), 1'b1);
		offer(OP_UNUSED, '0, 1'b0);
		offer(OP_CLEAR, ELEM_TOP, 1'b1);
		offer(OP_QUERY, ELEM_TOP, 1'b1);
		offer(OP_APPEND, ELEM_W'('h2AAA_AAAA), 1'b0);
		offer(OP_QUERY, ELEM_W'('h2AAA_AAAA), 1'b1);
		drain();

		// random: first round fills the store past capacity
		run_sequence(1'b1);
		for (int seq = 0; requests_sent < ITEMS + 17; seq++) begin
			if (seq % 8 == 7)
				drain();
			run_sequence(1'b0);
		end

		// wind down
		req_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
